// ===== hw/rtl/pcpsb_pkg.sv =====
// Package for the polar scan binner: widths, codes, state type and arctangent table.
// Used by every file in hw/rtl; depends on nothing.
package pcpsb_pkg;

    localparam int NUM_BINS_DEF = 181;
    localparam int COORD_W      = 18;
    localparam int RANGE_W      = 18;
    localparam int CH_W         = 8;
    localparam int CHSEL_W      = 9;
    localparam int BINNUM_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 18;
    localparam int SQ_W         = 36;
    localparam int CRD_W        = 42;
    localparam int ANG_W        = 27;
    localparam int CRD_STEPS    = 23;
    localparam int STEP_W       = 5;
    localparam int SQRT_STEPS   = 18;
    localparam int PRESCALE_SH  = 20;
    localparam int ANG_FRAC     = 24;

    localparam logic [RANGE_W-1:0] RESET_RANGE = 18'd160000;
    localparam logic signed [CHSEL_W-1:0] RESET_CHSEL = -9'sd1;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_RANGE    = 2'd1;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 27'sd16777216;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 27'sd8388608;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SQY,
        S_CORDIC,
        S_SCALE,
        S_DECIDE,
        S_RD,
        S_WR,
        S_RDA,
        S_OUT
    } state_t;

    function automatic logic [ANG_W-1:0] atan_lookup(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] t;
        case (i)
            5'd0:    t = 27'd4194304;
            5'd1:    t = 27'd2476042;
            5'd2:    t = 27'd1308273;
            5'd3:    t = 27'd664100;
            5'd4:    t = 27'd333339;
            5'd5:    t = 27'd166832;
            5'd6:    t = 27'd83436;
            5'd7:    t = 27'd41721;
            5'd8:    t = 27'd20861;
            5'd9:    t = 27'd10430;
            5'd10:   t = 27'd5215;
            5'd11:   t = 27'd2608;
            5'd12:   t = 27'd1304;
            5'd13:   t = 27'd652;
            5'd14:   t = 27'd326;
            5'd15:   t = 27'd163;
            5'd16:   t = 27'd81;
            5'd17:   t = 27'd41;
            5'd18:   t = 27'd20;
            5'd19:   t = 27'd10;
            5'd20:   t = 27'd5;
            5'd21:   t = 27'd3;
            5'd22:   t = 27'd1;
            default: t = 27'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/pcpsb_in_if.sv =====
// Point channel: valid/ready handshake carrying one action beat.
// Depends on pcpsb_pkg.
interface pcpsb_in_if
    import pcpsb_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic signed [COORD_W-1:0]  x_mm;
    logic signed [COORD_W-1:0]  y_mm;
    logic [CH_W-1:0]            channel;
    logic                       point_bad;
    logic [BINNUM_W-1:0]        read_bin;

    modport source (output valid, action, x_mm, y_mm, channel, point_bad, read_bin,
                    input ready);
    modport sink   (input valid, action, x_mm, y_mm, channel, point_bad, read_bin,
                    output ready);
endinterface

// ===== hw/rtl/pcpsb_out_if.sv =====
// Scan result channel: valid/ready handshake carrying one bin beat.
// Depends on pcpsb_pkg.
interface pcpsb_out_if
    import pcpsb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [BINNUM_W-1:0]   bin_number;
    logic [RANGE_W-1:0]    range_mm;

    modport source (output valid, bin_number, range_mm, input ready);
    modport sink   (input valid, bin_number, range_mm, output ready);
endinterface

// ===== hw/rtl/pcpsb_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on pcpsb_pkg.
module pcpsb_isqrt
    import pcpsb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SQ_W-1:0]    n,
    output logic               done,
    output logic [RANGE_W-1:0] root
);
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [SQ_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = n;
            r_next    = '0;
            bit_next  = {2'b01, {(SQ_W-2){1'b0}}};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                r_next   = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = !busy_reg;
    assign root = r_reg[RANGE_W-1:0];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < STEP_W'(SQRT_STEPS))
        else $error("sqrt step count overran");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == '0)
        else $error("sqrt did not start");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(cnt_reg) == STEP_W'(SQRT_STEPS - 1))
        else $error("sqrt finished early");
`endif

endmodule

// ===== hw/rtl/point_cloud_polar_scan_binner.sv =====
// Polar scan binner: one beat at a time. An add beat runs from accept to the next accept through
// 23 CORDIC steps on one shared set of adders plus setup, scaling and a read-modify-write
// of the bin memory; for a point on an axis, the 18-step square root sets the wait.
// A read beat passes through S_RDA and S_OUT and presents its result once the result
// register is free; a clear, dropped or unused beat leaves the block idle and ready.
// Reset is asynchronous, active low: bins read as 160000, channel_select -1.
// Depends on pcpsb_pkg, pcpsb_in_if, pcpsb_out_if and pcpsb_isqrt.
module point_cloud_polar_scan_binner
    import pcpsb_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    pcpsb_in_if.sink                point_in,
    pcpsb_out_if.source             scan_out
);
    localparam int BW   = $clog2(NUM_BINS);
    localparam int MW   = $clog2(NUM_BINS);
    localparam int PW   = ANG_W + 1 + MW;
    localparam logic [MW-1:0] SCALE_K = MW'(NUM_BINS - 1);

    state_t state_reg, state_next;

    logic signed [CHSEL_W-1:0] chsel_reg;
    logic [RANGE_W-1:0]        empty_reg;
    logic [RANGE_W-1:0]        fill_reg;
    logic [NUM_BINS-1:0]       vld_reg;

    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic signed [CRD_W-1:0]   cx_reg, cy_reg;
    logic signed [ANG_W-1:0]   z_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      special_reg;
    logic [SQ_W-1:0]           sqx_reg;
    logic [PW-1:0]             prod_reg;
    logic                      neg_reg;
    logic [BW-1:0]             addr_reg;
    logic [BINNUM_W-1:0]       rbin_reg;

    logic [RANGE_W-1:0] mem [NUM_BINS];
    logic [RANGE_W-1:0] mem_q;

    logic               out_valid_reg;
    logic [BINNUM_W-1:0] out_bin_reg;
    logic [RANGE_W-1:0] out_range_reg;

    logic               accept;
    logic               keep_point;
    logic               sq_start;
    logic               sq_done;
    logic [RANGE_W-1:0] sq_root;
    logic [SQ_W-1:0]    sq_n;
    logic signed [SQ_W-1:0] sq_prod;
    logic signed [COORD_W-1:0] sq_op;
    logic [RANGE_W-1:0] cur_range;
    logic               mem_we;
    logic               load_out;
    logic               drop;
    logic [PW-ANG_FRAC-1:0] idx_full;
    logic signed [ANG_W:0]  u_val;
    logic [ANG_W:0]         u_mag;
    logic signed [CRD_W-1:0] dx, dy;
    logic [ANG_W-1:0]       t_step;
    logic                   last_step;

    assign accept = point_in.valid && point_in.ready;
    assign keep_point = !point_in.point_bad &&
        (chsel_reg[CHSEL_W-1] || point_in.channel == chsel_reg[CH_W-1:0]);

    assign sq_op   = (state_reg == S_PREP) ? x_reg : y_reg;
    assign sq_prod = sq_op * sq_op;
    assign sq_n    = sqx_reg + SQ_W'(sq_prod);

    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;
    assign t_step = atan_lookup(step_reg);
    assign last_step = step_reg == STEP_W'(CRD_STEPS - 1);

    assign u_val = {z_reg[ANG_W-1], z_reg} + (ANG_W+1)'(ANG_HALF_PI);
    assign u_mag = u_val[ANG_W] ? (ANG_W+1)'(-u_val) : (ANG_W+1)'(u_val);

    assign idx_full = prod_reg[PW-1:ANG_FRAC];
    assign drop = neg_reg ? (idx_full != '0)
                          : (idx_full >= (PW-ANG_FRAC)'(NUM_BINS));

    assign cur_range = vld_reg[addr_reg] ? mem_q : fill_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(point_in.action))
                        ACT_ADD:
                        begin
                            if (keep_point)
                            begin
                                state_next = S_PREP;
                            end
                        end
                        ACT_READ:
                        begin
                            if (32'(point_in.read_bin) < NUM_BINS)
                            begin
                                state_next = S_RDA;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PREP:   state_next = S_SQY;
            S_SQY:    state_next = special_reg ? S_SCALE : S_CORDIC;
            S_CORDIC: state_next = last_step ? S_SCALE : S_CORDIC;
            S_SCALE:  state_next = S_DECIDE;
            S_DECIDE: state_next = drop ? S_IDLE : S_RD;
            S_RD:     state_next = S_WR;
            S_WR:     state_next = sq_done ? S_IDLE : S_WR;
            S_RDA:    state_next = S_OUT;
            S_OUT:    state_next = (!out_valid_reg || scan_out.ready) ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        point_in.ready = 1'b0;
        sq_start       = 1'b0;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            S_IDLE:  point_in.ready = 1'b1;
            S_SQY:   sq_start = 1'b1;
            S_WR:    mem_we = sq_done && (sq_root < cur_range);
            S_OUT:   load_out = !out_valid_reg || scan_out.ready;
            default: point_in.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chsel_reg     <= RESET_CHSEL;
            empty_reg     <= RESET_RANGE;
            fill_reg      <= RESET_RANGE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_CHANNEL_SELECT)
            begin
                chsel_reg <= cfg_data[CHSEL_W-1:0];
            end
            if (cfg_we && cfg_index == REG_EMPTY_RANGE)
            begin
                empty_reg <= cfg_data[RANGE_W-1:0];
            end
            if (accept && action_t'(point_in.action) == ACT_CLEAR)
            begin
                vld_reg  <= '0;
                fill_reg <= empty_reg;
            end
            if (mem_we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (scan_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_CORDIC)
            begin
                step_reg <= step_reg + 5'd1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= point_in.x_mm;
            y_reg    <= point_in.y_mm;
            rbin_reg <= point_in.read_bin;
            addr_reg <= BW'(point_in.read_bin);
        end
        case (state_reg)
            S_PREP:
            begin
                sqx_reg     <= SQ_W'(sq_prod);
                special_reg <= (x_reg == '0) || (y_reg == '0);
                if (x_reg == '0 && y_reg == '0)
                begin
                    z_reg <= '0;
                end
                else if (y_reg == '0)
                begin
                    z_reg <= x_reg[COORD_W-1] ? ANG_PI : '0;
                end
                else if (x_reg == '0)
                begin
                    z_reg <= y_reg[COORD_W-1] ? -ANG_HALF_PI : ANG_HALF_PI;
                end
                else if (x_reg[COORD_W-1])
                begin
                    z_reg <= y_reg[COORD_W-1] ? -ANG_PI : ANG_PI;
                end
                else
                begin
                    z_reg <= '0;
                end
                if (x_reg[COORD_W-1])
                begin
                    cx_reg <= -(CRD_W'(x_reg) <<< PRESCALE_SH);
                    cy_reg <= -(CRD_W'(y_reg) <<< PRESCALE_SH);
                end
                else
                begin
                    cx_reg <= CRD_W'(x_reg) <<< PRESCALE_SH;
                    cy_reg <= CRD_W'(y_reg) <<< PRESCALE_SH;
                end
            end
            S_CORDIC:
            begin
                if (!cy_reg[CRD_W-1])
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + $signed(t_step);
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - $signed(t_step);
                end
            end
            S_SCALE:
            begin
                prod_reg <= PW'(u_mag) * PW'(SCALE_K);
                neg_reg  <= u_val[ANG_W];
            end
            S_DECIDE:
            begin
                addr_reg <= neg_reg ? '0 : BW'(idx_full);
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
        if (load_out)
        begin
            out_bin_reg   <= rbin_reg;
            out_range_reg <= cur_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= sq_root;
        end
        mem_q <= mem[addr_reg];
    end

    pcpsb_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n     (sq_n),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign scan_out.valid      = out_valid_reg;
    assign scan_out.bin_number = out_bin_reg;
    assign scan_out.range_mm   = out_range_reg;

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action_t'(point_in.action) == ACT_CLEAR |=> vld_reg == '0)
        else $error("clear left valid bins");
    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside read path");
    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CORDIC |-> step_reg < STEP_W'(CRD_STEPS))
        else $error("cordic step overran");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> 32'(addr_reg) < NUM_BINS)
        else $error("bin write out of range");
`endif

endmodule

// ===== verif/tb_point_cloud_polar_scan_binner.sv =====
// Self-checking testbench for point_cloud_polar_scan_binner: directed table then random
// point, read and clear beats, checked against an in-bench polar binning predictor.
// Depends on pcpsb_pkg, pcpsb_in_if, pcpsb_out_if and the binner RTL.
module tb_point_cloud_polar_scan_binner;
    import pcpsb_pkg::*;

    typedef struct {
        action_t                   act;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [CH_W-1:0]           ch;
        logic                      bad;
        logic [BINNUM_W-1:0]       rb;
        bit                        typed;
        logic [RANGE_W-1:0]        rng;
    } beat_t;

    typedef struct {
        logic [BINNUM_W-1:0] bin_number;
        logic [RANGE_W-1:0]  range_mm;
    } bin_read_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pcpsb_in_if  point_in ();
    pcpsb_out_if scan_out ();

    point_cloud_polar_scan_binner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_in  (point_in.sink),
        .scan_out  (scan_out.source)
    );

    logic [RANGE_W-1:0] scan_bins [NUM_BINS_DEF];
    int                 sel_channel;
    logic [RANGE_W-1:0] clear_range;
    bin_read_t          pending_reads [$];
    beat_t              directed_rows [$];
    int                 mismatches;
    int                 src_idle_pct;
    int                 snk_idle_pct;
    int                 hold_requests;
    int                 hold_served;
    int                 hold_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint polar_angle(longint x, longint y);
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (y == 0)
            return (x > 0) ? 0 : 64'sd16777216;
        if (x == 0)
            return (y > 0) ? 64'sd8388608 : -64'sd8388608;
        cx = x * 64'sd1048576;
        cy = y * 64'sd1048576;
        if (x < 0)
        begin
            cx = -cx;
            cy = -cy;
            z = (y > 0) ? 64'sd16777216 : -64'sd16777216;
        end
        for (int i = 0; i < CRD_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + longint'(atan_lookup(STEP_W'(i)));
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - longint'(atan_lookup(STEP_W'(i)));
            end
        end
        return z;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic void scan_update(beat_t b);
        longint u;
        longint idx;
        longint x;
        longint y;
        longint r;
        bin_read_t rd;
        x = b.x;
        y = b.y;
        case (b.act)
            ACT_CLEAR:
                for (int i = 0; i < NUM_BINS_DEF; i++)
                    scan_bins[i] = clear_range;
            ACT_ADD:
            begin
                if (b.bad || (sel_channel >= 0 && int'(b.ch) != sel_channel))
                    return;
                u = polar_angle(x, y) + 64'sd8388608;
                if (u < 0)
                begin
                    if ((-u) * (NUM_BINS_DEF - 1) >= 64'sd16777216)
                        return;
                    idx = 0;
                end
                else
                begin
                    idx = (u * (NUM_BINS_DEF - 1)) >>> 24;
                    if (idx >= NUM_BINS_DEF)
                        return;
                end
                r = floor_sqrt(x * x + y * y);
                if (r < longint'(scan_bins[idx]))
                    scan_bins[idx] = r[RANGE_W-1:0];
            end
            ACT_READ:
                if (b.rb < NUM_BINS_DEF)
                begin
                    rd.bin_number = b.rb;
                    rd.range_mm = b.typed ? b.rng : scan_bins[b.rb];
                    pending_reads.push_back(rd);
                end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (scan_out.valid && scan_out.ready)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected beat bin %0d range %0d", $time,
                         scan_out.bin_number, scan_out.range_mm);
                mismatches++;
            end
            else
            begin
                if (scan_out.bin_number !== pending_reads[0].bin_number ||
                    scan_out.range_mm !== pending_reads[0].range_mm)
                begin
                    $display("%0t: expected bin %0d range %0d, actual bin %0d range %0d",
                             $time, pending_reads[0].bin_number, pending_reads[0].range_mm,
                             scan_out.bin_number, scan_out.range_mm);
                    mismatches++;
                end
                void'(pending_reads.pop_front());
            end
        end
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            scan_out.ready <= 1'b0;
        end
        else
            scan_out.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CHANNEL_SELECT)
            sel_channel = int'(signed'(data[CHSEL_W-1:0]));
        else if (idx == REG_EMPTY_RANGE)
            clear_range = data[RANGE_W-1:0];
    endtask

    task automatic drain();
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send(beat_t b);
        if ($urandom_range(99) < src_idle_pct)
        begin
            point_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        point_in.valid <= 1'b1;
        point_in.action <= b.act;
        point_in.x_mm <= b.x;
        point_in.y_mm <= b.y;
        point_in.channel <= b.ch;
        point_in.point_bad <= b.bad;
        point_in.read_bin <= b.rb;
        do
            @(posedge clk);
        while (!point_in.ready);
        scan_update(b);
    endtask

    function automatic beat_t row(action_t a, int x, int y, int ch, bit bad, int rb,
                                  bit typed = 0, int rng = 0);
        beat_t b;
        b.act = a;
        b.x = COORD_W'(x);
        b.y = COORD_W'(y);
        b.ch = CH_W'(ch);
        b.bad = bad;
        b.rb = BINNUM_W'(rb);
        b.typed = typed;
        b.rng = RANGE_W'(rng);
        return b;
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int pick;
        pick = $urandom_range(99);
        b.typed = 0;
        b.rng = '0;
        b.x = COORD_W'($urandom);
        b.y = COORD_W'($urandom);
        if ($urandom_range(3) == 0)
        begin
            b.x = $signed(18'($urandom_range(0, 400))) - 18'sd100;
            b.y = $signed(18'($urandom_range(0, 800))) - 18'sd400;
        end
        b.ch = ($urandom_range(2) == 0) ? 8'($urandom) : 8'(sel_channel);
        b.bad = ($urandom_range(9) == 0);
        b.rb = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180));
        if (pick < 60)
            b.act = ACT_ADD;
        else if (pick < 92)
            b.act = ACT_READ;
        else if (pick < 96)
            b.act = ACT_CLEAR;
        else
            b.act = ACT_NONE;
        return b;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send(random_beat());
    endtask

    initial
    begin
        mismatches = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        src_idle_pct = 20;
        snk_idle_pct = 71;
        sel_channel = -1;
        clear_range = RESET_RANGE;
        for (int i = 0; i < NUM_BINS_DEF; i++)
            scan_bins[i] = RESET_RANGE;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point_in.valid = 1'b0;
        point_in.action = ACT_NONE;
        point_in.x_mm = '0;
        point_in.y_mm = '0;
        point_in.channel = '0;
        point_in.point_bad = 1'b0;
        point_in.read_bin = '0;
        scan_out.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 0, 1, 160000));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 180, 1, 160000));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 181));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 255));
        directed_rows.push_back(row(ACT_NONE, 5, 5, 0, 0, 3));
        directed_rows.push_back(row(ACT_ADD, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 90, 1, 0));
        directed_rows.push_back(row(ACT_ADD, 0, 131071, 255, 0, 0));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 180, 1, 131071));
        directed_rows.push_back(row(ACT_ADD, 0, -131072, 7, 0, 0));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 0, 1, 131072));
        directed_rows.push_back(row(ACT_ADD, 3, 4, 0, 1, 0));
        directed_rows.push_back(row(ACT_ADD, -131072, 0, 0, 0, 0));
        directed_rows.push_back(row(ACT_ADD, -1, -131072, 0, 0, 0));
        directed_rows.push_back(row(ACT_ADD, -131072, -131072, 0, 0, 0));
        directed_rows.push_back(row(ACT_ADD, 131071, -131072, 0, 0, 0));
        directed_rows.push_back(row(ACT_ADD, 131071, 131071, 0, 0, 0));
        directed_rows.push_back(row(ACT_ADD, 131071, 0, 0, 0, 0));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 45));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 135));
        directed_rows.push_back(row(ACT_CLEAR, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(ACT_READ, 0, 0, 0, 0, 90, 1, 160000));
        foreach (directed_rows[i])
            send(directed_rows[i]);
        point_in.valid <= 1'b0;
        drain();

        write_reg(REG_CHANNEL_SELECT, 18'd5);
        write_reg(REG_EMPTY_RANGE, 18'd0);
        send(row(ACT_CLEAR, 0, 0, 0, 0, 0));
        send(row(ACT_READ, 0, 0, 0, 0, 17, 1, 0));
        random_phase(80);
        point_in.valid <= 1'b0;
        drain();
        write_reg(REG_EMPTY_RANGE, 18'd262143);
        send(row(ACT_CLEAR, 0, 0, 0, 0, 0));
        random_phase(80);
        point_in.valid <= 1'b0;
        drain();

        src_idle_pct = 71;
        snk_idle_pct = 20;
        write_reg(REG_CHANNEL_SELECT, 18'd255);
        write_reg(REG_EMPTY_RANGE, 18'd1000);
        random_phase(60);
        hold_requests++;
        random_phase(60);
        point_in.valid <= 1'b0;
        drain();
        write_reg(REG_CHANNEL_SELECT, 18'h100);
        random_phase(60);
        point_in.valid <= 1'b0;
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(REG_CHANNEL_SELECT, 18'h1FF);
        write_reg(REG_EMPTY_RANGE, 18'($urandom));
        send(row(ACT_CLEAR, 0, 0, 0, 0, 0));
        random_phase(80);
        point_in.valid <= 1'b0;
        drain();
        random_phase(80);
        point_in.valid <= 1'b0;
        drain();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== point_cloud_polar_scan_binner.f =====
hw/rtl/pcpsb_pkg.sv
hw/rtl/pcpsb_in_if.sv
hw/rtl/pcpsb_out_if.sv
hw/rtl/pcpsb_isqrt.sv
hw/rtl/point_cloud_polar_scan_binner.sv
verif/tb_point_cloud_polar_scan_binner.sv
